/* design/apa102_led_frame_encoder_defines.svh */
// Assertion macros for the frame encoder checker.
// Depends on nothing; every macro expects clk in scope, and the first two also rst_n.
`ifndef APA102_LED_FRAME_ENCODER_DEFINES_SVH
`define APA102_LED_FRAME_ENCODER_DEFINES_SVH

// Same-cycle implication, ignored while reset is held.
`define APA_CHK_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, ignored while reset is held.
`define APA_CHK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

// Next-cycle implication that also runs through reset.
`define APA_CHK_RESET(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

/* design/apa102_pkg.sv */
// Shared types and constants for the APA102 frame encoder.
// Depends on nothing; used by the palette RAM, the byte sequencer and the top level.
package apa102_pkg;

  // Palette geometry.
  localparam int PAL_ENTRIES = 16;
  localparam int PAL_AW      = (PAL_ENTRIES > 1) ? $clog2(PAL_ENTRIES) : 1;

  // Byte constants of the strip protocol.
  localparam logic [7:0] BYTE_ZERO = 8'h00;
  localparam logic [7:0] HDR_BASE  = 8'hE0;
  localparam logic [7:0] BYTE_FILL = 8'hFF;

  // Bytes in a start frame or a pixel, and the width of the byte counter
  // (a finish frame runs up to sixteen bytes).
  localparam int FRAME_BYTES = 4;
  localparam int LEFT_W      = 5;

  typedef enum logic [1:0] {
    REQ_START   = 2'd0,
    REQ_PIXEL   = 2'd1,
    REQ_FINISH  = 2'd2,
    REQ_PALETTE = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    CFG_BRIGHTNESS = 2'd0,
    CFG_RED_POS    = 2'd1,
    CFG_GREEN_POS  = 2'd2,
    CFG_BLUE_POS   = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [4:0] brightness;
    logic [1:0] red_pos;
    logic [1:0] green_pos;
    logic [1:0] blue_pos;
  } cfg_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  // One request waiting for the byte sequencer.
  typedef struct packed {
    req_t       req;
    logic       use_pal;
    logic [7:0] color;
    logic [7:0] count;
  } job_t;

endpackage

/* design/apa102_palette_ram.sv */
// Palette memory: one write port and one registered read port.
// Depends on apa102_pkg for depth and entry type.
module apa102_palette_ram (
  input  logic                         clk,
  input  logic                         wr_en,
  input  logic [apa102_pkg::PAL_AW-1:0] wr_addr,
  input  apa102_pkg::rgb_t             wr_data,
  input  logic                         rd_en,
  input  logic [apa102_pkg::PAL_AW-1:0] rd_addr,
  output apa102_pkg::rgb_t             rd_data
);

  apa102_pkg::rgb_t mem [apa102_pkg::PAL_ENTRIES];
  apa102_pkg::rgb_t rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port; the data holds until the next read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* design/apa102_byte_seq.sv */
// Byte sequencer: expands one request into its bytes and drives the output register.
// Depends on apa102_pkg for the request, config and colour types.
module apa102_byte_seq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              job_valid,
  input  apa102_pkg::job_t  job,
  input  apa102_pkg::rgb_t  pal,
  input  apa102_pkg::cfg_t  cfg,
  output logic              job_take,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        out_spi_byte,
  output logic              out_last_byte
);

  logic                          seq_valid_r, seq_valid_nxt;
  logic [apa102_pkg::LEFT_W-1:0] left_r, left_nxt;
  logic [31:0]                   bytes_r, bytes_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [7:0]                    spi_byte_r, spi_byte_nxt;
  logic                          last_byte_r, last_byte_nxt;

  logic                          out_load;
  logic                          seq_free;
  logic                          on_last;
  logic [7:0]                    red, green, blue;
  logic [7:0]                    slot0, slot1, slot2;
  logic [31:0]                   load_bytes;
  logic [apa102_pkg::LEFT_W-1:0] load_left;

  // Handshake between the sequencer and the output register.
  assign on_last  = (left_r == apa102_pkg::LEFT_W'(1));
  assign out_load = seq_valid_r && (!out_valid_r || !out_stall);
  assign seq_free = !seq_valid_r || (out_load && on_last);
  assign job_take = job_valid && seq_free;

  // Pixel colour: palette entry or flame colour from the low five index bits.
  always_comb begin
    if (job.use_pal) begin
      red   = pal.red;
      green = pal.green;
      blue  = pal.blue;
    end else begin
      red   = 8'({job.color[4:0], 1'b0}) + 8'd2;
      green = 8'(job.color[4:0]) + 8'd1;
      blue  = apa102_pkg::BYTE_ZERO;
    end
  end

  // Slot placement: later channels override earlier ones, position three places nothing.
  always_comb begin
    slot0 = apa102_pkg::BYTE_ZERO;
    slot1 = apa102_pkg::BYTE_ZERO;
    slot2 = apa102_pkg::BYTE_ZERO;
    if (cfg.red_pos == 2'd0) slot0 = red;
    if (cfg.red_pos == 2'd1) slot1 = red;
    if (cfg.red_pos == 2'd2) slot2 = red;
    if (cfg.green_pos == 2'd0) slot0 = green;
    if (cfg.green_pos == 2'd1) slot1 = green;
    if (cfg.green_pos == 2'd2) slot2 = green;
    if (cfg.blue_pos == 2'd0) slot0 = blue;
    if (cfg.blue_pos == 2'd1) slot1 = blue;
    if (cfg.blue_pos == 2'd2) slot2 = blue;
  end

  // Bytes and byte count of the request being loaded.
  always_comb begin
    case (job.req)
      apa102_pkg::REQ_START: begin
        load_bytes = {4{apa102_pkg::BYTE_ZERO}};
        load_left  = apa102_pkg::LEFT_W'(apa102_pkg::FRAME_BYTES);
      end
      apa102_pkg::REQ_PIXEL: begin
        load_bytes = {apa102_pkg::HDR_BASE | {3'b000, cfg.brightness}, slot0, slot1, slot2};
        load_left  = apa102_pkg::LEFT_W'(apa102_pkg::FRAME_BYTES);
      end
      apa102_pkg::REQ_FINISH: begin
        load_bytes = {4{apa102_pkg::BYTE_FILL}};
        load_left  = apa102_pkg::LEFT_W'(job.count[7:4]) + apa102_pkg::LEFT_W'(1);
      end
      default: begin
        load_bytes = {4{apa102_pkg::BYTE_ZERO}};
        load_left  = apa102_pkg::LEFT_W'(apa102_pkg::FRAME_BYTES);
      end
    endcase
  end

  // Sequencer state: load a new request or shift out one byte.
  always_comb begin
    seq_valid_nxt = seq_valid_r;
    left_nxt      = left_r;
    bytes_nxt     = bytes_r;
    if (job_take) begin
      seq_valid_nxt = 1'b1;
      left_nxt      = load_left;
      bytes_nxt     = load_bytes;
    end else if (out_load) begin
      seq_valid_nxt = !on_last;
      left_nxt      = left_r - apa102_pkg::LEFT_W'(1);
      bytes_nxt     = {bytes_r[23:0], apa102_pkg::BYTE_FILL};
    end
  end

  // Output register.
  always_comb begin
    out_valid_nxt = out_valid_r;
    spi_byte_nxt  = spi_byte_r;
    last_byte_nxt = last_byte_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
      spi_byte_nxt  = bytes_r[31:24];
      last_byte_nxt = on_last;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      seq_valid_r <= seq_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    left_r      <= left_nxt;
    bytes_r     <= bytes_nxt;
    spi_byte_r  <= spi_byte_nxt;
    last_byte_r <= last_byte_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_spi_byte  = spi_byte_r;
  assign out_last_byte = last_byte_r;

endmodule

/* design/apa102_led_frame_encoder.sv */
// Top level of the APA102 frame encoder: config registers, request slot, palette and sequencer.
// Depends on apa102_pkg, apa102_palette_ram and apa102_byte_seq.
//
//   channel | direction | handshake          | payload
//   in_     | input     | in_valid/in_stall  | req_type, color_index, led_count, entry_*
//   out_    | output    | out_valid/out_stall| spi_byte, last_byte
//   cfg_    | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One byte leaves per cycle while out_stall is low: start and pixel requests give 4 bytes,
// a finish request gives (led_count>>4)+1 bytes, and a palette write gives none.
// The byte sequencer sets the rate; the next request loads in the cycle its predecessor
// hands out its last byte. The palette read is issued on the accept beat and is ready
// in the cycle after it. rst_n is synchronous; the palette is not cleared. Output stalls
// back up through the sequencer into in_stall; cfg_ready is always high.
module apa102_led_frame_encoder (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_req_type,
  input  logic [7:0] in_color_index,
  input  logic [7:0] in_led_count,
  input  logic [3:0] in_entry_index,
  input  logic [7:0] in_entry_red,
  input  logic [7:0] in_entry_green,
  input  logic [7:0] in_entry_blue,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_spi_byte,
  output logic       out_last_byte,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);

  apa102_pkg::cfg_t cfg_r, cfg_nxt;
  logic             job_valid_r, job_valid_nxt;
  apa102_pkg::job_t job_r, job_nxt;

  apa102_pkg::req_t req;
  apa102_pkg::rgb_t wr_rgb;
  apa102_pkg::rgb_t pal_rgb;
  logic             accept;
  logic             job_take;
  logic             is_pal_idx;
  logic             pal_wr_en;
  logic             pal_rd_en;

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      case (apa102_pkg::cfg_idx_t'(cfg_index))
        apa102_pkg::CFG_BRIGHTNESS: cfg_nxt.brightness = cfg_data[4:0];
        apa102_pkg::CFG_RED_POS:    cfg_nxt.red_pos    = cfg_data[1:0];
        apa102_pkg::CFG_GREEN_POS:  cfg_nxt.green_pos  = cfg_data[1:0];
        apa102_pkg::CFG_BLUE_POS:   cfg_nxt.blue_pos   = cfg_data[1:0];
        default:                    cfg_nxt            = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.brightness <= 5'd31;
      cfg_r.red_pos    <= 2'd0;
      cfg_r.green_pos  <= 2'd1;
      cfg_r.blue_pos   <= 2'd2;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Input accept: the request slot is free or empties this cycle.
  assign req        = apa102_pkg::req_t'(in_req_type);
  assign in_stall   = job_valid_r && !job_take;
  assign accept     = in_valid && !in_stall;
  assign is_pal_idx = (in_color_index < 8'(apa102_pkg::PAL_ENTRIES));

  // Palette access is issued on the accept beat.
  assign pal_wr_en = accept && (req == apa102_pkg::REQ_PALETTE) &&
                     (8'(in_entry_index) < 8'(apa102_pkg::PAL_ENTRIES));
  assign pal_rd_en = accept && (req == apa102_pkg::REQ_PIXEL) && is_pal_idx;
  assign wr_rgb    = '{red: in_entry_red, green: in_entry_green, blue: in_entry_blue};

  // Request slot ahead of the sequencer; palette writes do not occupy it.
  always_comb begin
    job_valid_nxt = job_valid_r;
    job_nxt       = job_r;
    if (job_take) begin
      job_valid_nxt = 1'b0;
    end
    if (accept && (req != apa102_pkg::REQ_PALETTE)) begin
      job_valid_nxt   = 1'b1;
      job_nxt.req     = req;
      job_nxt.use_pal = is_pal_idx;
      job_nxt.color   = in_color_index;
      job_nxt.count   = in_led_count;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_valid_r <= 1'b0;
    end else begin
      job_valid_r <= job_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r <= job_nxt;
  end

  apa102_palette_ram u_pal (
    .clk     (clk),
    .wr_en   (pal_wr_en),
    .wr_addr (apa102_pkg::PAL_AW'(in_entry_index)),
    .wr_data (wr_rgb),
    .rd_en   (pal_rd_en),
    .rd_addr (apa102_pkg::PAL_AW'(in_color_index)),
    .rd_data (pal_rgb)
  );

  apa102_byte_seq u_seq (
    .clk           (clk),
    .rst_n         (rst_n),
    .job_valid     (job_valid_r),
    .job           (job_r),
    .pal           (pal_rgb),
    .cfg           (cfg_r),
    .job_take      (job_take),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_spi_byte  (out_spi_byte),
    .out_last_byte (out_last_byte)
  );

endmodule

/* design/apa102_checker.sv */
// Port-level checks for the APA102 frame encoder, bound to the top level.
// Depends on apa102_led_frame_encoder_defines.svh for the assertion macros.
`include "apa102_led_frame_encoder_defines.svh"

module apa102_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_spi_byte,
  input logic       out_last_byte,
  input logic       cfg_valid,
  input logic       cfg_ready
);

  // A stalled output beat keeps its byte and its end marker.
  `APA_CHK_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_spi_byte) && $stable(out_last_byte), "stalled output beat changed")

  // Reset leaves no output beat pending.
  `APA_CHK_RESET(a_reset_empty, !rst_n, !out_valid, "output valid right after reset")

  // The configuration port never refuses a write.
  `APA_CHK_IMPL(a_cfg_ready, cfg_valid, cfg_ready, "configuration write refused")

  // With the output side stalled and a beat waiting, a stalled input stays stalled for as long
  // as out_stall and in_valid stay high: stall stays up once it is up.
  `APA_CHK_NEXT(a_in_backpressure, in_valid && in_stall && out_valid && out_stall, in_stall || !out_stall || !in_valid, "input taken while output held")

endmodule

bind apa102_led_frame_encoder apa102_checker u_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_spi_byte  (out_spi_byte),
  .out_last_byte (out_last_byte),
  .cfg_valid     (cfg_valid),
  .cfg_ready     (cfg_ready)
);
